// File: rtl/gsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsi_pkg
// shared types, constants and state encoding for the sample interpolator
// ----------------------------------------------------------------------------
package gsi_pkg;

    localparam int TABLE_DEPTH_DEF   = 1024;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int STAMP_W           = 48;
    localparam int VAL_W             = 24;
    localparam int SIDX_W            = 10;
    // fill value for invalid field data: zero (half of the file fill, scaled out)
    localparam logic [VAL_W-1:0] FILL_HALF = '0;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               mode;
        logic [STAMP_W-1:0]       stamp_ms;
        logic signed [VAL_W-1:0]  in_bx;
        logic signed [VAL_W-1:0]  in_by;
        logic signed [VAL_W-1:0]  in_bz;
        logic signed [VAL_W-1:0]  in_vx;
        logic signed [VAL_W-1:0]  in_kp;
        logic                     in_field_ok;
        logic                     in_vx_ok;
        logic                     in_kp_ok;
    } gsi_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  out_bx;
        logic signed [VAL_W-1:0]  out_by;
        logic signed [VAL_W-1:0]  out_bz;
        logic signed [VAL_W-1:0]  out_vx;
        logic signed [VAL_W-1:0]  out_kp;
        logic                     field_found;
        logic [1:0]               status;
        logic [SIDX_W-1:0]        start_index;
    } gsi_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UP,
        ST_DOWN,
        ST_RDLO,
        ST_RDHI,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } gsi_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic append;
        logic clear;
        logic rd_i;      // read entry at scan pointer
        logic step_i;    // advance scan pointer
        logic init_up;   // hi pointer from i
        logic rd_up;     // read entry at hi pointer
        logic step_up;
        logic init_dn;   // lo pointer from i-1
        logic rd_dn;     // read entry at lo pointer
        logic step_dn;
        logic rd_lo;
        logic rd_hi;
        logic cap_lo;
        logic cap_hi;
        logic div_init;
        logic div_step;
        logic mul;
        logic sum;
        logic finish;
    } gsi_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
        logic is_append;
        logic is_clear;
        logic empty;
        logic scan_stop;  // i == cnt or stamp[i] > t (data valid)
        logic up_stop;
        logic dn_stop;
        logic div_done;
    } gsi_stat_t;

endpackage
`default_nettype wire

// File: rtl/gsi_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsi_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module gsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: rtl/gsi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsi_ctrl
// sequencer for clear, append and the query walk
// ----------------------------------------------------------------------------
module gsi_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_fire,
    input  wire logic               out_free,
    input  wire gsi_pkg::gsi_stat_t st,
    output gsi_pkg::gsi_cmd_t       cmd,
    output logic                    busy
);
    import gsi_pkg::*;

    gsi_state_t state_reg, state_next;
    // every table read is split into an issue phase, then a look phase
    logic       ph_reg, ph_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ph_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ph_next    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!st.is_query)
                begin
                    state_next = ST_IDLE;
                end
                else if (st.empty)
                begin
                    state_next = ST_OUT;
                end
                else if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else if (st.scan_stop)
                begin
                    state_next = ST_UP;
                end
            end
            ST_UP:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else if (st.up_stop)
                begin
                    state_next = ST_DOWN;
                end
            end
            ST_DOWN:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else if (st.dn_stop)
                begin
                    state_next = ST_RDLO;
                end
            end
            ST_RDLO:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    state_next = ST_RDHI;
                end
            end
            ST_RDHI:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (ph_reg && st.div_done)
                begin
                    state_next = ST_MUL;
                end
                ph_next = 1'b1;
            end
            ST_MUL:    state_next = ST_SUM;
            ST_SUM:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_in = in_fire;
            end
            ST_SCAN:
            begin
                cmd.append = !ph_reg && st.is_append;
                cmd.clear  = !ph_reg && st.is_clear;
                cmd.rd_i   = st.is_query && !st.empty && !ph_reg;
                cmd.step_i = st.is_query && !st.empty && ph_reg && !st.scan_stop;
                cmd.init_up = st.is_query && !st.empty && ph_reg && st.scan_stop;
            end
            ST_UP:
            begin
                cmd.rd_up   = !ph_reg;
                cmd.step_up = ph_reg && !st.up_stop;
                cmd.init_dn = ph_reg && st.up_stop;
            end
            ST_DOWN:
            begin
                cmd.rd_dn   = !ph_reg;
                cmd.step_dn = ph_reg && !st.dn_stop;
            end
            ST_RDLO:
            begin
                cmd.rd_lo  = !ph_reg;
                cmd.cap_lo = ph_reg;
            end
            ST_RDHI:
            begin
                cmd.rd_hi  = !ph_reg;
                cmd.cap_hi = ph_reg;
            end
            ST_DIV:
            begin
                cmd.div_init = !ph_reg;
                cmd.div_step = ph_reg && !st.div_done;
            end
            ST_MUL:    cmd.mul = 1'b1;
            ST_SUM:    cmd.sum = 1'b1;
            ST_OUT:    cmd.finish = out_free;
            default:   cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/gsi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsi_datapath
// sample table, bracket pointers, weight divider and blend arithmetic
// ----------------------------------------------------------------------------
module gsi_datapath #(
    parameter int TABLE_DEPTH   = gsi_pkg::TABLE_DEPTH_DEF,
    parameter int FRACTION_BITS = gsi_pkg::FRACTION_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gsi_pkg::gsi_in_t   in_beat,
    input  wire gsi_pkg::gsi_cmd_t  cmd,
    output gsi_pkg::gsi_stat_t      st,
    output gsi_pkg::gsi_out_t       res
);
    import gsi_pkg::*;

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = AW + 1;
    localparam int FB  = FRACTION_BITS;
    localparam int ENT = STAMP_W + 5 * VAL_W + 3;
    localparam int PW  = VAL_W + FB + 1;   // product width
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [VAL_W:0] BIAS = (VAL_W+1)'(1) << (VAL_W - 1);

    typedef struct packed {
        logic [STAMP_W-1:0] t;
        logic [VAL_W-1:0]   bx;
        logic [VAL_W-1:0]   by;
        logic [VAL_W-1:0]   bz;
        logic [VAL_W-1:0]   vx;
        logic [VAL_W-1:0]   kp;
        logic               fok;
        logic               vok;
        logic               kok;
    } ent_t;

    gsi_in_t        in_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  i_reg, hi_reg;
    logic [CW:0]    lo_reg;         // signed walk, may reach -1
    ent_t           elo_reg, ehi_reg;
    ent_t           rd;
    logic [ENT-1:0] rdata;
    logic [AW-1:0]  addr;
    logic           we;
    logic [CW-1:0]  hi_c;
    logic [CW-1:0]  lo_c;

    // division state
    logic [STAMP_W:0]   rem_reg;
    logic [STAMP_W-1:0] den_reg;
    logic [FB:0]        q_reg;
    logic [$clog2(FB+1)-1:0] k_reg;
    logic [FB:0]        v_reg;
    logic [STAMP_W:0]   rem_sh;
    logic [STAMP_W-1:0] num_c;
    logic [STAMP_W-1:0] den_c;

    logic               range_bad;
    logic               vlo, vhi;
    logic [PW-1:0]      pa_reg [5];
    logic [PW-1:0]      pb_reg [5];
    gsi_out_t           res_reg;
    gsi_out_t           empty_res;

    assign we   = cmd.append && (cnt_reg < DEPTH_C);
    assign rd   = ent_t'(rdata);

    always_comb
    begin
        addr = i_reg[AW-1:0];
        if (we)
        begin
            addr = cnt_reg[AW-1:0];
        end
        else if (cmd.rd_lo)
        begin
            addr = lo_c[AW-1:0];
        end
        else if (cmd.rd_hi)
        begin
            addr = hi_c[AW-1:0];
        end
        else if (cmd.rd_up)
        begin
            addr = hi_reg[AW-1:0];
        end
        else if (cmd.rd_dn)
        begin
            addr = lo_reg[AW-1:0];
        end
    end

    gsi_ram #(.WIDTH(ENT), .DEPTH(TABLE_DEPTH)) u_tab (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata ({in_reg.stamp_ms, in_reg.in_bx, in_reg.in_by, in_reg.in_bz,
                 in_reg.in_vx, in_reg.in_kp, in_reg.in_field_ok,
                 in_reg.in_vx_ok, in_reg.in_kp_ok}),
        .rdata (rdata)
    );

    assign hi_c = (hi_reg >= cnt_reg) ? cnt_reg - 1'b1 : hi_reg;
    assign lo_c = lo_reg[CW] ? '0 : lo_reg[CW-1:0];

    assign st.is_query  = (in_reg.mode == MODE_QUERY);
    assign st.is_append = (in_reg.mode == MODE_APPEND);
    assign st.is_clear  = (in_reg.mode == MODE_CLEAR);
    assign st.empty     = (cnt_reg == '0);
    assign st.scan_stop = (i_reg == cnt_reg) || (rd.t > in_reg.stamp_ms);
    assign st.up_stop   = (hi_reg >= cnt_reg) || rd.fok;
    assign st.dn_stop   = lo_reg[CW] || rd.fok;
    assign st.div_done  = (k_reg == '0);

    assign cnt_next = cmd.clear ? '0 : (we ? cnt_reg + 1'b1 : cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign range_bad = (lo_c != hi_c) &&
                       ((in_reg.stamp_ms < elo_reg.t) || (in_reg.stamp_ms > ehi_reg.t));
    assign vlo    = elo_reg.fok;
    assign vhi    = ehi_reg.fok;
    assign rem_sh = {rem_reg[STAMP_W-1:0], 1'b0};
    assign num_c  = in_reg.stamp_ms - elo_reg.t;
    assign den_c  = ehi_reg.t - elo_reg.t;

    always_comb
    begin
        empty_res        = '0;
        empty_res.status = STAT_EMPTY;
    end

    function automatic logic [VAL_W:0] biased(input logic [VAL_W-1:0] x);
        biased = {1'b0, x} ^ BIAS;
    endfunction

    function automatic logic [VAL_W-1:0] pick(input logic [VAL_W-1:0] x, input logic ok);
        pick = ok ? x : '0;
    endfunction

    logic [VAL_W-1:0] av [5];
    logic [VAL_W-1:0] bv [5];
    logic [FB:0]      wa, wb;
    logic             bothv;

    assign bothv = vlo && vhi;
    // one valid bracket copies: both operands from it, weight irrelevant
    always_comb
    begin
        ent_t a, b;
        a = vlo ? elo_reg : ehi_reg;
        b = vhi ? ehi_reg : elo_reg;
        av[0] = a.bx;  bv[0] = b.bx;
        av[1] = a.by;  bv[1] = b.by;
        av[2] = a.bz;  bv[2] = b.bz;
        av[3] = pick(a.vx, a.vok);  bv[3] = pick(b.vx, b.vok);
        av[4] = pick(a.kp, a.kok);  bv[4] = pick(b.kp, b.kok);
        wb = bothv ? v_reg : '0;
        wa = ((FB+1)'(1) << FB) - wb;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_beat;
        end
        if (cmd.load_in)
        begin
            i_reg <= '0;
        end
        else if (cmd.step_i)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.init_up)
        begin
            hi_reg <= i_reg;
        end
        else if (cmd.step_up)
        begin
            hi_reg <= hi_reg + 1'b1;
        end
        if (cmd.init_dn)
        begin
            lo_reg <= {1'b0, i_reg} - 1'b1;
        end
        else if (cmd.step_dn)
        begin
            lo_reg <= lo_reg - 1'b1;
        end
        if (cmd.cap_lo)
        begin
            elo_reg <= rd;
        end
        if (cmd.cap_hi)
        begin
            ehi_reg <= rd;
        end
        if (cmd.div_init)
        begin
            q_reg   <= '0;
            den_reg <= den_c;
            rem_reg <= {1'b0, num_c};
            if (lo_c == hi_c)
            begin
                v_reg <= '0;
                k_reg <= '0;
            end
            else if (num_c >= den_c)
            begin
                // coinciding stamps give zero weight
                v_reg <= (den_c != '0) ? ((FB+1)'(1) << FB) : '0;
                k_reg <= '0;
            end
            else
            begin
                k_reg <= ($clog2(FB+1))'(FB);
            end
        end
        else if (cmd.div_step)
        begin
            k_reg <= k_reg - 1'b1;
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                q_reg   <= {q_reg[FB-1:0], 1'b1};
                if (k_reg == ($clog2(FB+1))'(1))
                begin
                    v_reg <= {q_reg[FB-1:0], 1'b1};
                end
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[FB-1:0], 1'b0};
                if (k_reg == ($clog2(FB+1))'(1))
                begin
                    v_reg <= {q_reg[FB-1:0], 1'b0};
                end
            end
        end
        if (cmd.mul)
        begin
            for (int n = 0; n < 5; n++)
            begin
                pa_reg[n] <= PW'(biased(av[n])) * PW'(wa);
                pb_reg[n] <= PW'(biased(bv[n])) * PW'(wb);
            end
        end
        if (cmd.sum)
        begin
            logic [PW:0] s;
            logic [VAL_W-1:0] r [5];
            for (int n = 0; n < 5; n++)
            begin
                s    = {1'b0, pa_reg[n]} + {1'b0, pb_reg[n]} + ((PW+1)'(1) << (FB - 1));
                r[n] = s[FB +: VAL_W] ^ BIAS[VAL_W-1:0];
            end
            res_reg.start_index <= SIDX_W'(lo_c);
            res_reg.status      <= range_bad ? STAT_RANGE : STAT_OK;
            res_reg.field_found <= (vlo || vhi) && !range_bad;
            res_reg.out_bx <= (vlo || vhi) && !range_bad ? r[0] : FILL_HALF;
            res_reg.out_by <= (vlo || vhi) && !range_bad ? r[1] : FILL_HALF;
            res_reg.out_bz <= (vlo || vhi) && !range_bad ? r[2] : FILL_HALF;
            res_reg.out_vx <= (vlo || vhi) && !range_bad ? r[3] : '0;
            res_reg.out_kp <= (vlo || vhi) && !range_bad ? r[4] : '0;
        end
        else if (st.is_query && st.empty && cmd.rd_i == 1'b0 && cmd.load_in == 1'b0
                 && cmd.finish == 1'b0)
        begin
            res_reg <= empty_res;
        end
    end

    assign res = res_reg;
endmodule
`default_nettype wire

// File: rtl/gap_skipping_sample_interpolator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gap_skipping_sample_interpolator_core
// time-series sample table with gap-skipping linear interpolation
// ----------------------------------------------------------------------------
// Clear and append beats give no result. A query walks the single-port
// sample ram, issuing a read and then looking at each entry: a forward scan to
// the first later stamp, then outward past samples with invalid field data,
// then restoring division for the weight and the multiply and rounding. One
// item is in flight at a time; the result waits in an output register.
// ----------------------------------------------------------------------------
module gap_skipping_sample_interpolator_core #(
    parameter int TABLE_DEPTH   = gsi_pkg::TABLE_DEPTH_DEF,
    parameter int FRACTION_BITS = gsi_pkg::FRACTION_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire gsi_pkg::gsi_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gsi_pkg::gsi_out_t      out_data
);
    import gsi_pkg::*;

    gsi_cmd_t  cmd;
    gsi_stat_t st;
    logic      busy;
    logic      in_fire;
    logic      out_pending;

    assign in_ready  = !busy;
    assign in_fire   = in_valid && in_ready;

    gsi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_ready),
        .st       (st),
        .cmd      (cmd),
        .busy     (busy)
    );

    gsi_datapath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_beat (in_data),
        .cmd     (cmd),
        .st      (st),
        .res     (out_data)
    );

    assign out_valid = out_pending;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_pending <= 1'b0;
        end
        else
        begin
            out_pending <= cmd.finish ? 1'b0
                           : ((cmd.sum || (st.is_query && st.empty && !cmd.load_in && busy))
                              ? 1'b1 : out_pending);
        end
    end
endmodule
`default_nettype wire

// File: rtl/gsi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsi_checker
// port-level checks on the interpolator handshakes and result codes
// ----------------------------------------------------------------------------
module gsi_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire gsi_pkg::gsi_out_t out_data
);
    import gsi_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result right after input beat");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != 2'd3)
        else $error("bad status code");

    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STAT_OK |-> !out_data.field_found)
        else $error("field found with bad status");
endmodule

bind gap_skipping_sample_interpolator_core gsi_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the sample interpolator core: table loads and clears, then queries
// compared field by field against a behavioral interpolator kept in step
// ----------------------------------------------------------------------------
module testbench;
    import gsi_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int FB    = FRACTION_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int LONG_FILL = 60;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    gsi_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    gsi_out_t out_data;

    gap_skipping_sample_interpolator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // shadow copy of the sample table
    int unsigned       tbl_count;
    logic [47:0]       tbl_stamp [DEPTH];
    logic signed [23:0] tbl_bx [DEPTH];
    logic signed [23:0] tbl_by [DEPTH];
    logic signed [23:0] tbl_bz [DEPTH];
    logic signed [23:0] tbl_vx [DEPTH];
    logic signed [23:0] tbl_kp [DEPTH];
    logic [2:0]        tbl_ok [DEPTH];

    gsi_out_t pending_results[$];
    int       errors;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       quiet_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] interp_weight(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = 0;
        r = num;
        if (num >= den)
            return (den != 0) ? (64'd1 << FB) : 64'd0;
        for (int k = 0; k < FB; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [23:0] mix_values(logic signed [23:0] a,
                                                      logic signed [23:0] b,
                                                      logic [63:0] w);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] s;
        ua = {40'd0, ~a[23], a[22:0]};
        ub = {40'd0, ~b[23], b[22:0]};
        s = ua * ((64'd1 << FB) - w) + ub * w + (64'd1 << (FB - 1));
        s = s >> FB;
        return {~s[23], s[22:0]};
    endfunction

    function automatic logic signed [23:0] speed_at(int unsigned i);
        return tbl_ok[i][1] ? tbl_vx[i] : 24'sd0;
    endfunction

    function automatic logic signed [23:0] index_at(int unsigned i);
        return tbl_ok[i][2] ? tbl_kp[i] : 24'sd0;
    endfunction

    // updates the shadow table and returns 1 when a result is due
    function automatic bit apply_beat(gsi_in_t it, output gsi_out_t res);
        int unsigned i;
        int unsigned hi;
        int unsigned lo;
        int          lo_s;
        logic [63:0] w;
        bit          vlo;
        bit          vhi;
        int unsigned s;
        res = '0;
        if (it.mode == MODE_CLEAR)
        begin
            tbl_count = 0;
            return 0;
        end
        if (it.mode == MODE_APPEND)
        begin
            if (tbl_count < DEPTH)
            begin
                tbl_stamp[tbl_count] = it.stamp_ms;
                tbl_bx[tbl_count] = it.in_bx;
                tbl_by[tbl_count] = it.in_by;
                tbl_bz[tbl_count] = it.in_bz;
                tbl_vx[tbl_count] = it.in_vx;
                tbl_kp[tbl_count] = it.in_kp;
                tbl_ok[tbl_count] = {it.in_kp_ok, it.in_vx_ok, it.in_field_ok};
                tbl_count++;
            end
            return 0;
        end
        if (it.mode != MODE_QUERY)
            return 0;
        if (tbl_count == 0)
        begin
            res.status = STAT_EMPTY;
            return 1;
        end
        i = 0;
        while (i < tbl_count && tbl_stamp[i] <= it.stamp_ms)
            i++;
        hi = i;
        while (hi < tbl_count && !tbl_ok[hi][0])
            hi++;
        lo_s = int'(i) - 1;
        while (lo_s >= 0 && !tbl_ok[lo_s][0])
            lo_s--;
        lo = (lo_s < 0) ? 0 : lo_s;
        if (hi >= tbl_count)
            hi = tbl_count - 1;
        res.start_index = lo[9:0];
        if (lo != hi && (it.stamp_ms < tbl_stamp[lo] || it.stamp_ms > tbl_stamp[hi]))
        begin
            res.status = STAT_RANGE;
            return 1;
        end
        w = 0;
        if (lo != hi)
            w = interp_weight(it.stamp_ms - tbl_stamp[lo], tbl_stamp[hi] - tbl_stamp[lo]);
        vlo = tbl_ok[lo][0];
        vhi = tbl_ok[hi][0];
        res.status = STAT_OK;
        if (vlo && vhi)
        begin
            res.out_bx = mix_values(tbl_bx[lo], tbl_bx[hi], w);
            res.out_by = mix_values(tbl_by[lo], tbl_by[hi], w);
            res.out_bz = mix_values(tbl_bz[lo], tbl_bz[hi], w);
            res.out_vx = mix_values(speed_at(lo), speed_at(hi), w);
            res.out_kp = mix_values(index_at(lo), index_at(hi), w);
            res.field_found = 1'b1;
        end
        else if (vlo || vhi)
        begin
            s = vlo ? lo : hi;
            res.out_bx = tbl_bx[s];
            res.out_by = tbl_by[s];
            res.out_bz = tbl_bz[s];
            res.out_vx = speed_at(s);
            res.out_kp = index_at(s);
            res.field_found = 1'b1;
        end
        return 1;
    endfunction

    // valid stays high after a beat until the next call drives it
    task automatic send_beat(gsi_in_t it);
        gsi_out_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (apply_beat(it, res))
            pending_results.push_back(res);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic gsi_in_t make_sample(logic [47:0] t, bit f, bit v, bit k);
        gsi_in_t it;
        it = '0;
        it.mode = MODE_APPEND;
        it.stamp_ms = t;
        it.in_bx = 24'($urandom);
        it.in_by = 24'($urandom);
        it.in_bz = 24'($urandom);
        it.in_vx = 24'($urandom);
        it.in_kp = 24'($urandom);
        it.in_field_ok = f;
        it.in_vx_ok = v;
        it.in_kp_ok = k;
        return it;
    endfunction

    function automatic gsi_in_t make_query(logic [47:0] t);
        gsi_in_t it;
        it = '0;
        it.mode = MODE_QUERY;
        it.stamp_ms = t;
        return it;
    endfunction

    function automatic gsi_in_t make_clear();
        gsi_in_t it;
        it = '0;
        it.mode = MODE_CLEAR;
        it.stamp_ms = 48'({$urandom, $urandom});
        return it;
    endfunction

    task automatic test_directed();
        gsi_in_t it;
        send_beat(make_query(48'd5));                      // empty table
        it = make_sample(48'd100, 1, 1, 1);
        it.in_bx = 24'sh7fffff;
        it.in_by = 24'sh800000;
        it.in_bz = 24'sh000000;
        send_beat(it);
        send_beat(make_query(48'd100));                    // single sample
        it = make_sample(48'd300, 1, 0, 1);
        it.in_bx = 24'sh800000;
        it.in_by = 24'sh7fffff;
        send_beat(it);
        send_beat(make_query(48'd200));                    // midpoint blend
        send_beat(make_query(48'd300));
        send_beat(make_query(48'd50));                     // before the table
        send_beat(make_query(48'hffff_ffff_ffff));         // after the table
        send_beat(make_sample(48'd400, 0, 1, 1));          // field gap
        send_beat(make_sample(48'd500, 0, 0, 0));
        send_beat(make_sample(48'd600, 1, 1, 0));
        send_beat(make_query(48'd450));                    // skip across the gap
        send_beat(make_sample(48'd600, 1, 0, 0));          // equal stamps
        send_beat(make_query(48'd600));
        send_beat(make_sample(48'd10, 1, 1, 1));           // unsorted stamp
        send_beat(make_query(48'd20));
        it = make_query(48'd0);
        it.mode = 2'd3;                                    // unused mode
        send_beat(it);
        send_beat(make_clear());
        send_beat(make_sample(48'd7, 0, 1, 1));            // no valid bracket
        send_beat(make_sample(48'd9, 0, 1, 1));
        send_beat(make_query(48'd8));
        send_beat(make_clear());
        send_beat(make_query(48'd8));
        wait_drained();
    endtask

    task automatic test_long_table();
        send_beat(make_clear());
        for (int n = 0; n < LONG_FILL; n++)
            send_beat(make_sample(48'd1000 + 48'(n) * 48'd10, $urandom_range(3) != 0, 1, 1));
        send_beat(make_query(48'd1000 + 48'(LONG_FILL) * 48'd10 - 48'd5));
        send_beat(make_query(48'd1005));
        send_beat(make_query(48'hffff_ffff_ffff));
        wait_drained();
    endtask

    task automatic test_random(int n_items);
        logic [47:0] t;
        int          n;
        n = 0;
        t = '0;
        while (n < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_beat(make_clear());
                t = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom})
                                             : 48'($urandom_range(1000));
            end
            else if ($urandom_range(9) < 4 || tbl_count == 0)
            begin
                // mostly rising stamps, sometimes out of order or wide
                if ($urandom_range(9) == 0)
                    t = 48'({$urandom, $urandom});
                else
                    t = t + 48'($urandom_range(200));
                send_beat(make_sample(t, $urandom_range(2) != 0, $urandom_range(1) != 0,
                                      $urandom_range(1) != 0));
            end
            else
            begin
                send_beat(make_query(($urandom_range(7) == 0) ? 48'({$urandom, $urandom})
                                     : t - 48'($urandom_range(600)) + 48'($urandom_range(100))));
            end
            n++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        gsi_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_data);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.out_bx !== want.out_bx || out_data.out_by !== want.out_by ||
                    out_data.out_bz !== want.out_bz || out_data.out_vx !== want.out_vx ||
                    out_data.out_kp !== want.out_kp ||
                    out_data.field_found !== want.field_found ||
                    out_data.status !== want.status ||
                    out_data.start_index !== want.start_index)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** gap_skipping_sample_interpolator_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        tbl_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 18;
        recv_idle_pct = 78;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(70);
        wait_drained();
        send_idle_pct = 78;
        recv_idle_pct = 18;
        test_long_table();
        test_random(70);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(70);
        wait_drained();
        if (errors == 0 && pending_results.size() == 0)
            $display("** gap_skipping_sample_interpolator_core: PASSED **");
        else
            $display("** gap_skipping_sample_interpolator_core: FAILED **");
        $finish;
    end

endmodule
